>>> rtl/flc_pkg.sv
// Package: sizes, payload structs and pipeline tag for the linear convolution block.
`default_nettype none
package flc_pkg;

  localparam int MAX_FIRST_LEN  = 32;
  localparam int MAX_SECOND_LEN = 32;
  localparam int SAMPLE_WIDTH   = 16;

  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int POS_W       = 6;
  localparam int VALUE_W     = 37;
  localparam int IN_W        = 16;

  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int ACC_W  = (PROD_W + CNT_W > VALUE_W) ? PROD_W + CNT_W : VALUE_W;

  typedef struct packed {
    logic                   kind;
    logic signed [IN_W-1:0] sample;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] conv_value;
    logic [POS_W-1:0]          position;
    logic                      final_res;
    logic                      dropped;
  } out_item_t;

  // one multiply-accumulate term travelling down the MAC pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             final_res;
    logic [POS_W-1:0] position;
  } flc_tag_t;

endpackage
`default_nettype wire

>>> rtl/full_linear_convolution_top.sv
// Top level: sample stores, term sequencer and MAC pipeline for full linear convolution.
`default_nettype none
// Load: one element per cycle; busy stays low, so items may follow back to back.
// Compute: a last G element raises busy; the sequencer issues all N*M MAC terms, one
//   term per cycle from the two store read ports, then waits for the pipeline to drain.
// Each term passes the store read, product and result registers; results are strobed
//   for one cycle each and cannot be stalled. Empty runs go from the check state to idle.
// Synchronous active-high reset clears counts, drop flag, sequencer and strobes;
//   store contents are left as they are.
module full_linear_convolution_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire flc_pkg::in_item_t  item,
  output logic                    busy,
  output logic                    result_valid,
  output flc_pkg::out_item_t      result
);
  import flc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_RUN   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  first_count;
  logic [CNT_W-1:0]  second_count;
  logic              overflow_seen;
  logic [POS_W-1:0]  i;
  logic [ADDR_W-1:0] j;
  logic              term_first;

  logic              accept;
  logic              f_we;
  logic              g_we;
  logic              f_full;
  logic              g_full;
  logic [SAMPLE_WIDTH-1:0] wdata;

  logic [CNT_W-1:0]  n_m1;
  logic [CNT_W-1:0]  i_ext;
  logic [CNT_W-1:0]  hi_full;
  logic [ADDR_W-1:0] hi;
  logic [CNT_W:0]    i2;
  logic [CNT_W:0]    m_ext;
  logic [CNT_W:0]    lo_full;
  logic [CNT_W:0]    last_i;
  logic              term_last;
  logic              run_final;
  logic [POS_W-1:0]  g_diff;
  logic [ADDR_W-1:0] g_raddr;

  logic [SAMPLE_WIDTH-1:0] f_rdata;
  logic [SAMPLE_WIDTH-1:0] g_rdata;
  flc_tag_t          issue;
  logic              pending;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // a store is full once its count reaches the capacity; the element is then dropped
  assign f_full = (first_count  >= CNT_W'(MAX_FIRST_LEN));
  assign g_full = (second_count >= CNT_W'(MAX_SECOND_LEN));
  assign f_we   = accept && !item.kind && !f_full;
  assign g_we   = accept &&  item.kind && !g_full;
  assign wdata  = item.sample[SAMPLE_WIDTH-1:0];

  // term range for output i: j runs lo..hi, with hi = min(i, n-1)
  assign n_m1    = first_count - CNT_W'(1);
  assign i_ext   = CNT_W'(i);
  assign hi_full = (i_ext < n_m1) ? i_ext : n_m1;
  assign hi      = hi_full[ADDR_W-1:0];

  // lo of the next output: max(0, i+2-m)
  assign i2      = (CNT_W+1)'(i) + (CNT_W+1)'(2);
  assign m_ext   = (CNT_W+1)'(second_count);
  assign lo_full = (i2 > m_ext) ? (i2 - m_ext) : '0;

  assign last_i    = (CNT_W+1)'(first_count) + (CNT_W+1)'(second_count) - (CNT_W+1)'(2);
  assign term_last = (j == hi);
  assign run_final = term_last && ((CNT_W+1)'(i) == last_i);

  assign g_diff  = i - POS_W'(j);
  assign g_raddr = g_diff[ADDR_W-1:0];

  assign issue.valid     = (state == S_RUN);
  assign issue.first     = term_first;
  assign issue.last      = term_last;
  assign issue.final_res = run_final;
  assign issue.position  = i;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      i             <= '0;
      j             <= '0;
      term_first    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (f_we) begin
              first_count <= first_count + CNT_W'(1);
            end
            if (g_we) begin
              second_count <= second_count + CNT_W'(1);
            end
            if ((!item.kind && f_full) || (item.kind && g_full)) begin
              overflow_seen <= 1'b1;
            end
            if (item.kind && item.last) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (first_count == '0 || second_count == '0) begin
            first_count   <= '0;
            second_count  <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end else begin
            i          <= '0;
            j          <= '0;
            term_first <= 1'b1;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          if (term_last) begin
            if (run_final) begin
              state <= S_DRAIN;
            end else begin
              i          <= i + POS_W'(1);
              j          <= lo_full[ADDR_W-1:0];
              term_first <= 1'b1;
            end
          end else begin
            j          <= j + ADDR_W'(1);
            term_first <= 1'b0;
          end
        end
        S_DRAIN: begin
          // hold busy until the last transfer has left the result register
          if (!pending) begin
            first_count   <= '0;
            second_count  <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // writes happen only while idle and reads only while running, so the
  // store ports never touch the same entry in one cycle
  flc_ram #(
    .DEPTH(STORE_DEPTH),
    .WIDTH(SAMPLE_WIDTH)
  ) u_first_store (
    .clk  (clk),
    .we   (f_we),
    .waddr(first_count[ADDR_W-1:0]),
    .wdata(wdata),
    .re   (issue.valid),
    .raddr(j),
    .rdata(f_rdata)
  );

  flc_ram #(
    .DEPTH(STORE_DEPTH),
    .WIDTH(SAMPLE_WIDTH)
  ) u_second_store (
    .clk  (clk),
    .we   (g_we),
    .waddr(second_count[ADDR_W-1:0]),
    .wdata(wdata),
    .re   (issue.valid),
    .raddr(g_raddr),
    .rdata(g_rdata)
  );

  flc_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .f_data      (f_rdata),
    .g_data      (g_rdata),
    .dropped     (overflow_seen),
    .result_valid(result_valid),
    .result      (result),
    .pending     (pending)
  );

endmodule
`default_nettype wire

>>> rtl/flc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module flc_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/flc_mac.sv
// Pipelined multiply-accumulate: tag align, product register, accumulator and result register.
`default_nettype none
module flc_mac (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire flc_pkg::flc_tag_t                      issue,
  input  wire logic signed [flc_pkg::SAMPLE_WIDTH-1:0] f_data,
  input  wire logic signed [flc_pkg::SAMPLE_WIDTH-1:0] g_data,
  input  wire logic                                   dropped,
  output logic                                        result_valid,
  output flc_pkg::out_item_t                          result,
  output logic                                        pending
);
  import flc_pkg::*;

  flc_tag_t                  tag1;
  flc_tag_t                  tag2;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_next;

  // tag1 lines up with the RAM read data, tag2 with the product
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid   <= 1'b0;
      tag2.valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      tag1.valid   <= issue.valid;
      tag2.valid   <= tag1.valid;
      result_valid <= tag2.valid && tag2.last;
    end
    tag1.first     <= issue.first;
    tag1.last      <= issue.last;
    tag1.final_res <= issue.final_res;
    tag1.position  <= issue.position;
    tag2.first     <= tag1.first;
    tag2.last      <= tag1.last;
    tag2.final_res <= tag1.final_res;
    tag2.position  <= tag1.position;
    prod           <= PROD_W'(f_data) * PROD_W'(g_data);
  end

  assign acc_next = (tag2.first ? ACC_W'(0) : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (tag2.valid) begin
      acc <= acc_next;
    end
    if (tag2.valid && tag2.last) begin
      result.conv_value <= acc_next[VALUE_W-1:0];
      result.position   <= tag2.position;
      result.final_res  <= tag2.final_res;
      result.dropped    <= dropped;
    end
  end

  assign pending = tag1.valid || tag2.valid || result_valid;

endmodule
`default_nettype wire

>>> rtl/flc_checker.sv
// Port-level checker for the convolution top level, with its bind.
`default_nettype none
module flc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire flc_pkg::in_item_t  item,
  input wire logic               busy,
  input wire logic               result_valid,
  input wire flc_pkg::out_item_t result
);
  import flc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> (!busy && !result_valid))
    else $error("busy or result strobe after reset");

  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result transfer outside a run");

  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !(item.kind && item.last)) |=> !busy)
    else $error("load transfer raised busy");

  a_last_g_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind && item.last) |=> busy)
    else $error("last G element did not start a run");

  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.final_res) |=> !result_valid)
    else $error("result transfer right after the final one");

endmodule

bind full_linear_convolution_top flc_checker u_flc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .item        (item),
  .busy        (busy),
  .result_valid(result_valid),
  .result      (result)
);
`default_nettype wire
